// ----- rtl/sll_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sll_pkg: shared types and codes for the static linked list engine
// Holds the command and status codes, the beat structs of both channels and
// the default node array size.
// ----------------------------------------------------------------------------
package sll_pkg;

    // Default number of node slots, including the two head slots.
    localparam int SLOTS_DEFAULT = 256;

    // Command codes.
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_DELETE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // Input beat.
    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] position;
        logic [7:0] data_in;
    } in_beat_t;

    // Result beat.
    typedef struct packed {
        logic [1:0] status;
        logic [7:0] data_out;
        logic [7:0] list_length;
    } out_beat_t;

endpackage

// ----- rtl/static_linked_list_engine.sv -----
`timescale 1ns / 1ps
// Throughput: one command at a time; the cost is set by the cursor walk,
// one read a cycle.
// Reset: after aresetn the cursor memory is rebuilt one slot a cycle, and
// s_ready stays low until that pass has finished.
// ----------------------------------------------------------------------------
// static_linked_list_engine: cursor-linked byte list with a free chain
// A small sequencer drives one cursor memory and one data memory. An in-range
// insert, delete or read walks the cursors to the position; insert and delete
// relink the nodes. Each command returns a status, a data byte and the list length.
// ----------------------------------------------------------------------------
module static_linked_list_engine #(
    parameter int SLOTS = sll_pkg::SLOTS_DEFAULT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sll_pkg::in_beat_t    s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sll_pkg::out_beat_t   m_data
);

    localparam int IW   = $clog2(SLOTS);
    localparam int CMPW = ((IW > 8) ? IW : 8) + 1;

    localparam logic [IW-1:0] HEAD      = IW'(SLOTS - 1);
    localparam logic [IW-1:0] FREE_HEAD = '0;
    localparam logic [IW-1:0] LAST_FREE = IW'(SLOTS - 2);

    // Sequencer state codes.
    localparam logic [3:0] S_INIT      = 4'd0;
    localparam logic [3:0] S_IDLE      = 4'd1;
    localparam logic [3:0] S_INS_FRESH = 4'd2;
    localparam logic [3:0] S_INS_POP   = 4'd3;
    localparam logic [3:0] S_WALK      = 4'd4;
    localparam logic [3:0] S_INS_HOOK  = 4'd5;
    localparam logic [3:0] S_DEL_RD    = 4'd6;
    localparam logic [3:0] S_DEL_FREE  = 4'd7;
    localparam logic [3:0] S_DEL_PUSH  = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    // Memories.
    logic [IW-1:0] cur_mem [SLOTS];
    logic [7:0]    dat_mem [SLOTS];

    logic          cur_we;
    logic [IW-1:0] cur_waddr;
    logic [IW-1:0] cur_wdata;
    logic          cur_re;
    logic [IW-1:0] cur_raddr;
    logic [IW-1:0] cur_rdata_reg;

    logic          dat_we;
    logic [IW-1:0] dat_waddr;
    logic [7:0]    dat_wdata;
    logic          dat_re;
    logic [IW-1:0] dat_raddr;
    logic [7:0]    dat_rdata_reg;

    // Sequencer and datapath registers.
    logic [3:0]          state_reg,      state_next;
    logic [IW-1:0]       init_idx_reg,   init_idx_next;
    logic [IW-1:0]       count_reg,      count_next;
    logic [1:0]          cmd_reg,        cmd_next;
    logic [7:0]          din_reg,        din_next;
    logic [7:0]          rem_reg,        rem_next;
    logic [IW-1:0]       addr_reg,       addr_next;
    logic [IW-1:0]       fresh_reg,      fresh_next;
    logic [IW-1:0]       prev_reg,       prev_next;
    logic [IW-1:0]       link_reg,       link_next;
    logic [1:0]          res_status_reg, res_status_next;
    logic [7:0]          res_data_reg,   res_data_next;
    logic                m_valid_reg,    m_valid_next;
    sll_pkg::out_beat_t  m_data_reg,     m_data_next;

    logic [CMPW-1:0] pos_ext;
    logic [CMPW-1:0] cnt_ext;
    logic            ins_bad;
    logic            acc_bad;
    logic            in_fire;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;
    assign in_fire = s_valid && s_ready;

    // Position range checks against the current length.
    assign pos_ext = CMPW'(s_data.position);
    assign cnt_ext = CMPW'(count_reg);
    assign ins_bad = (pos_ext == '0) || (pos_ext > cnt_ext + CMPW'(1));
    assign acc_bad = (pos_ext == '0) || (pos_ext > cnt_ext);

    // Cursor memory: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (cur_we) begin
            cur_mem[cur_waddr] <= cur_wdata;
        end
        if (cur_re) begin
            cur_rdata_reg <= cur_mem[cur_raddr];
        end
    end

    // Data memory: one write and one registered read a cycle.
    always_ff @(posedge aclk) begin
        if (dat_we) begin
            dat_mem[dat_waddr] <= dat_wdata;
        end
        if (dat_re) begin
            dat_rdata_reg <= dat_mem[dat_raddr];
        end
    end

    // Sequencer: next state, memory controls and datapath updates.
    always_comb begin
        state_next      = state_reg;
        init_idx_next   = init_idx_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        din_next        = din_reg;
        rem_next        = rem_reg;
        addr_next       = addr_reg;
        fresh_next      = fresh_reg;
        prev_next       = prev_reg;
        link_next       = link_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_data_next     = m_data_reg;

        cur_we    = 1'b0;
        cur_waddr = '0;
        cur_wdata = '0;
        cur_re    = 1'b0;
        cur_raddr = '0;
        dat_we    = 1'b0;
        dat_waddr = '0;
        dat_wdata = '0;
        dat_re    = 1'b0;
        dat_raddr = '0;

        case (state_reg)
            S_INIT: begin
                // Rebuild the free chain; both chain ends and the list head hold zero.
                cur_we        = 1'b1;
                cur_waddr     = init_idx_reg;
                cur_wdata     = (init_idx_reg >= LAST_FREE) ? '0 : init_idx_reg + IW'(1);
                init_idx_next = init_idx_reg + IW'(1);
                if (init_idx_reg == HEAD) begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE: begin
                if (in_fire) begin
                    cmd_next        = s_data.cmd;
                    din_next        = s_data.data_in;
                    rem_next        = s_data.position - 8'd1;
                    res_status_next = sll_pkg::ST_OK;
                    res_data_next   = 8'd0;
                    if (s_data.cmd == sll_pkg::CMD_INSERT) begin
                        if (ins_bad) begin
                            res_status_next = sll_pkg::ST_RANGE;
                            state_next      = S_FINISH;
                        end else begin
                            // Fetch the first free node.
                            cur_re     = 1'b1;
                            cur_raddr  = FREE_HEAD;
                            state_next = S_INS_FRESH;
                        end
                    end else if (s_data.cmd inside {sll_pkg::CMD_DELETE, sll_pkg::CMD_READ}) begin
                        if (acc_bad) begin
                            res_status_next = sll_pkg::ST_RANGE;
                            state_next      = S_FINISH;
                        end else begin
                            // Start the walk at the list head.
                            cur_re     = 1'b1;
                            cur_raddr  = HEAD;
                            addr_next  = HEAD;
                            state_next = S_WALK;
                        end
                    end else begin
                        state_next = S_FINISH;
                    end
                end
            end

            S_INS_FRESH: begin
                if (cur_rdata_reg == '0) begin
                    res_status_next = sll_pkg::ST_FULL;
                    state_next      = S_FINISH;
                end else begin
                    fresh_next = cur_rdata_reg;
                    cur_re     = 1'b1;
                    cur_raddr  = cur_rdata_reg;
                    state_next = S_INS_POP;
                end
            end

            S_INS_POP: begin
                // Unhook the fresh node from the free chain and store the byte.
                cur_we     = 1'b1;
                cur_waddr  = FREE_HEAD;
                cur_wdata  = cur_rdata_reg;
                dat_we     = 1'b1;
                dat_waddr  = fresh_reg;
                dat_wdata  = din_reg;
                cur_re     = 1'b1;
                cur_raddr  = HEAD;
                addr_next  = HEAD;
                state_next = S_WALK;
            end

            S_WALK: begin
                // One cursor read a cycle; the last read gives the node after prev.
                if (rem_reg == 8'd0) begin
                    prev_next = addr_reg;
                    link_next = cur_rdata_reg;
                    if (cmd_reg == sll_pkg::CMD_INSERT) begin
                        cur_we     = 1'b1;
                        cur_waddr  = fresh_reg;
                        cur_wdata  = cur_rdata_reg;
                        state_next = S_INS_HOOK;
                    end else begin
                        cur_re     = 1'b1;
                        cur_raddr  = cur_rdata_reg;
                        dat_re     = 1'b1;
                        dat_raddr  = cur_rdata_reg;
                        state_next = S_DEL_RD;
                    end
                end else begin
                    cur_re    = 1'b1;
                    cur_raddr = cur_rdata_reg;
                    addr_next = cur_rdata_reg;
                    rem_next  = rem_reg - 8'd1;
                end
            end

            S_INS_HOOK: begin
                cur_we     = 1'b1;
                cur_waddr  = prev_reg;
                cur_wdata  = fresh_reg;
                count_next = count_reg + IW'(1);
                state_next = S_FINISH;
            end

            S_DEL_RD: begin
                res_data_next = dat_rdata_reg;
                if (cmd_reg == sll_pkg::CMD_READ) begin
                    state_next = S_FINISH;
                end else begin
                    // Bypass the target and fetch the free chain head.
                    cur_we     = 1'b1;
                    cur_waddr  = prev_reg;
                    cur_wdata  = cur_rdata_reg;
                    cur_re     = 1'b1;
                    cur_raddr  = FREE_HEAD;
                    state_next = S_DEL_FREE;
                end
            end

            S_DEL_FREE: begin
                cur_we     = 1'b1;
                cur_waddr  = link_reg;
                cur_wdata  = cur_rdata_reg;
                state_next = S_DEL_PUSH;
            end

            S_DEL_PUSH: begin
                cur_we     = 1'b1;
                cur_waddr  = FREE_HEAD;
                cur_wdata  = link_reg;
                count_next = count_reg - IW'(1);
                state_next = S_FINISH;
            end

            S_FINISH: begin
                // Load the output register once the previous beat has left.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next            = 1'b1;
                    m_data_next.status      = res_status_reg;
                    m_data_next.data_out    = res_data_reg;
                    m_data_next.list_length = cnt_ext[7:0];
                    state_next              = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            init_idx_reg <= '0;
            count_reg    <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            init_idx_reg <= init_idx_next;
            count_reg    <= count_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        din_reg        <= din_next;
        rem_reg        <= rem_next;
        addr_reg       <= addr_next;
        fresh_reg      <= fresh_next;
        prev_reg       <= prev_next;
        link_reg       <= link_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        m_data_reg     <= m_data_next;
    end

endmodule
